// ----- hw/rtl/bct_pkg.sv -----
// ----------------------------------------------------------------------------
// bct_pkg
// Shared types and constants for the Bezier curve tessellator.
// ----------------------------------------------------------------------------
package bct_pkg;

    localparam int COORD_W      = 24;
    localparam int SEG_W        = 6;
    localparam int MAX_SEGMENTS = 63;
    localparam int T_W          = 16;   // t, unsigned Q0.16
    localparam int U_W          = 17;   // u = 1 - t, unsigned Q1.16
    localparam int Q_W          = 17;   // 65536 / n
    localparam int W_W          = 33;   // Bernstein weight, Q0.32 plus headroom
    localparam int MA_W         = 36;   // multiplier operand a (signed)
    localparam int MB_W         = 25;   // multiplier operand b (signed)
    localparam int PROD_W       = MA_W + MB_W;
    localparam int ACC_W        = 60;
    localparam int STEP_W       = 4;
    localparam int DIV_STEPS    = 17;
    localparam int FIFO_DEPTH   = 2;

    localparam logic [U_W-1:0] T_ONE = U_W'(65536);

    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

    // sequencer steps of the point engine
    localparam logic [STEP_W-1:0] ST_UU  = 4'd0;
    localparam logic [STEP_W-1:0] ST_TT  = 4'd1;
    localparam logic [STEP_W-1:0] ST_W1  = 4'd2;
    localparam logic [STEP_W-1:0] ST_W2  = 4'd3;
    localparam logic [STEP_W-1:0] ST_W0  = 4'd4;
    localparam logic [STEP_W-1:0] ST_W3  = 4'd5;
    localparam logic [STEP_W-1:0] ST_X0  = 4'd6;
    localparam logic [STEP_W-1:0] ST_Y0  = 4'd7;
    localparam logic [STEP_W-1:0] ST_X1  = 4'd8;
    localparam logic [STEP_W-1:0] ST_Y1  = 4'd9;
    localparam logic [STEP_W-1:0] ST_X2  = 4'd10;
    localparam logic [STEP_W-1:0] ST_Y2  = 4'd11;
    localparam logic [STEP_W-1:0] ST_X3  = 4'd12;
    localparam logic [STEP_W-1:0] ST_Y3  = 4'd13;
    localparam logic [STEP_W-1:0] ST_ACC = 4'd14;
    localparam logic [STEP_W-1:0] ST_OUT = 4'd15;

    localparam logic DEG_QUAD  = 1'b0;
    localparam logic DEG_CUBIC = 1'b1;

    typedef struct packed {
        logic                      degree;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] ctrl_a_x;
        logic signed [COORD_W-1:0] ctrl_a_y;
        logic signed [COORD_W-1:0] ctrl_b_x;
        logic signed [COORD_W-1:0] ctrl_b_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic [SEG_W-1:0]          segment_count;
    } in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [SEG_W-1:0]          point_index;
        logic                      last;
    } out_t;

    // classified request: clamped count plus step of t per point
    typedef struct packed {
        logic                      degree;
        logic signed [COORD_W-1:0] p0_x;
        logic signed [COORD_W-1:0] p0_y;
        logic signed [COORD_W-1:0] p1_x;
        logic signed [COORD_W-1:0] p1_y;
        logic signed [COORD_W-1:0] p2_x;
        logic signed [COORD_W-1:0] p2_y;
        logic signed [COORD_W-1:0] p3_x;
        logic signed [COORD_W-1:0] p3_y;
        logic [SEG_W-1:0]          n;
        logic [Q_W-1:0]            q;
        logic [SEG_W-1:0]          r;
    } job_t;

    typedef struct packed {
        logic             start;
        logic [SEG_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [Q_W-1:0]   quo;
        logic [SEG_W-1:0] rem;
    } div_rsp_t;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_DIV,
        FE_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        BE_IDLE,
        BE_CALC,
        BE_LAST
    } back_state_t;

endpackage

// ----- hw/rtl/bezier_curve_tessellator.sv -----
// Path from request to first point: the divide, the job queue, then the point
// sequence; 0 segments skips the divide and the sequence and gives the end point.
// Throughput is set by the single shared multiplier in the point engine, which
// walks every step of one curve point before it starts the next one.
// Reset (aresetn low, synchronous) empties the job queue and drops any item
// in flight; no per-request state survives.
// ----------------------------------------------------------------------------
// bezier_curve_tessellator
// Quadratic / cubic Bezier tessellator: request in, N+1 curve points out.
// ----------------------------------------------------------------------------
module bezier_curve_tessellator (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  bct_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output bct_pkg::out_t m_data
);
    import bct_pkg::*;

    logic push, full, pop, empty;
    job_t wr_job, rd_job;

    bct_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .push    (push),
        .job     (wr_job),
        .full    (full)
    );

    bct_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_data (wr_job),
        .full    (full),
        .pop     (pop),
        .rd_data (rd_job),
        .empty   (empty)
    );

    bct_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .empty   (empty),
        .rd_data (rd_job),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- hw/rtl/bct_div.sv -----
// ----------------------------------------------------------------------------
// bct_div
// Restoring divider, one quotient bit per cycle: 65536 / n and 65536 % n.
// ----------------------------------------------------------------------------
module bct_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  bct_pkg::div_req_t req,
    output bct_pkg::div_rsp_t rsp
);
    import bct_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [4:0]       cnt_reg;
    logic [SEG_W-1:0] div_reg;
    logic [SEG_W-1:0] rem_reg;
    logic [Q_W-1:0]   dvd_reg;   // dividend shifts out, quotient shifts in

    logic [SEG_W:0]   trial;
    logic             ge;
    logic [SEG_W-1:0] rem_next;

    assign trial    = {rem_reg, dvd_reg[Q_W-1]};
    assign ge       = trial >= {1'b0, div_reg};
    assign rem_next = ge ? SEG_W'(trial - {1'b0, div_reg}) : trial[SEG_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            div_reg <= req.divisor;
            rem_reg <= '0;
            dvd_reg <= Q_W'(T_ONE);
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[Q_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = dvd_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ----- hw/rtl/bct_front.sv -----
// ----------------------------------------------------------------------------
// bct_front
// Takes a curve request, clamps the segment count and works out the
// per-point step of t, then queues the job.
// ----------------------------------------------------------------------------
module bct_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  bct_pkg::in_t  s_data,
    output logic          push,
    output bct_pkg::job_t job,
    input  logic          full
);
    import bct_pkg::*;

    front_state_t state_reg, state_next;
    job_t         job_reg;
    logic         accept;
    logic [SEG_W-1:0] n_clamp;
    div_req_t     dreq;
    div_rsp_t     drsp;

    assign n_clamp = (s_data.segment_count > SEG_W'(MAX_SEGMENTS)) ?
                     SEG_W'(MAX_SEGMENTS) : s_data.segment_count;

    bct_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FE_IDLE: if (accept) state_next = (n_clamp == '0) ? FE_PUSH : FE_DIV;
            FE_DIV:  if (drsp.done) state_next = FE_PUSH;
            FE_PUSH: if (!full) state_next = FE_IDLE;
            default: state_next = FE_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        push         = 1'b0;
        case (state_reg)
            FE_IDLE: s_ready = 1'b1;
            FE_PUSH: push    = !full;
            default: ;
        endcase
        accept       = s_valid && s_ready;
        dreq.start   = accept && (n_clamp != '0);
        dreq.divisor = n_clamp;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FE_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            job_reg.degree <= s_data.degree;
            job_reg.p0_x   <= s_data.start_x;
            job_reg.p0_y   <= s_data.start_y;
            job_reg.p1_x   <= s_data.ctrl_a_x;
            job_reg.p1_y   <= s_data.ctrl_a_y;
            job_reg.p2_x   <= s_data.ctrl_b_x;
            job_reg.p2_y   <= s_data.ctrl_b_y;
            job_reg.p3_x   <= s_data.end_x;
            job_reg.p3_y   <= s_data.end_y;
            job_reg.n      <= n_clamp;
            job_reg.q      <= '0;
            job_reg.r      <= '0;
        end else if (state_reg == FE_DIV && drsp.done) begin
            job_reg.q <= drsp.quo;
            job_reg.r <= drsp.rem;
        end
    end

    assign job = job_reg;

endmodule

// ----- hw/rtl/bct_fifo.sv -----
// ----------------------------------------------------------------------------
// bct_fifo
// Short job queue between the request front end and the point engine.
// ----------------------------------------------------------------------------
module bct_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  bct_pkg::job_t wr_data,
    output logic          full,
    input  logic          pop,
    output bct_pkg::job_t rd_data,
    output logic          empty
);
    import bct_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);

    job_t          mem [FIFO_DEPTH];
    job_t          rd_data_reg;
    logic [AW-1:0] wptr_reg;
    logic [AW-1:0] rptr_reg;
    logic [AW-1:0] rptr_next;
    logic [AW:0]   cnt_reg;

    assign full      = cnt_reg == (AW+1)'(FIFO_DEPTH);
    assign empty     = cnt_reg == '0;
    assign rptr_next = pop ? rptr_reg + AW'(1) : rptr_reg;
    assign rd_data   = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) wptr_reg <= wptr_reg + AW'(1);
            rptr_reg <= rptr_next;
            if (push && !pop) cnt_reg <= cnt_reg + (AW+1)'(1);
            else if (pop && !push) cnt_reg <= cnt_reg - (AW+1)'(1);
        end
    end

    // head item is registered; a push into the next head slot passes through
    always_ff @(posedge aclk) begin
        if (push) mem[wptr_reg] <= wr_data;
        rd_data_reg <= (push && wptr_reg == rptr_next) ? wr_data : mem[rptr_next];
    end

endmodule

// ----- hw/rtl/bct_back.sv -----
// ----------------------------------------------------------------------------
// bct_back
// Point engine: one shared multiplier walks the weight products and the
// weighted sums for each point but the last, then rounds and saturates.
// ----------------------------------------------------------------------------
module bct_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          empty,
    input  bct_pkg::job_t rd_data,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output bct_pkg::out_t m_data
);
    import bct_pkg::*;

    back_state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg;
    job_t              job_reg;
    logic [SEG_W-1:0]  idx_reg;
    logic [T_W-1:0]    t_reg;
    logic [SEG_W-1:0]  r_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [W_W-1:0]    uu_reg, tt_reg;
    logic [W_W-1:0]    w_reg [4];
    logic signed [ACC_W-1:0] accx_reg, accy_reg;
    out_t              out_reg;
    logic              out_valid_reg;

    logic [U_W-1:0]    u;
    logic signed [MA_W-1:0] ma;
    logic signed [MB_W-1:0] mb;
    logic              cubic;
    logic              out_free, load_pt, load_last;
    logic [SEG_W:0]    r_sum;
    logic              t_carry;
    logic [W_W-1:0]    w_cub;
    logic [W_W-1:0]    w_rnd;

    function automatic logic [MA_W-1:0] za(input logic [W_W-1:0] v);
        za = MA_W'(v);
    endfunction

    function automatic logic signed [MB_W-1:0] sc(input logic signed [COORD_W-1:0] v);
        sc = {v[COORD_W-1], v};
    endfunction

    // floor((acc + 2^31) / 2^32), clipped to the coordinate range
    function automatic logic signed [COORD_W-1:0] rsat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0]    b;
        logic signed [ACC_W-33:0]   s;
        b = a + ACC_W'(64'h8000_0000);
        s = b[ACC_W-1:32];
        if (s > (ACC_W-32)'(COORD_MAX))      rsat = COORD_MAX;
        else if (s < (ACC_W-32)'(COORD_MIN)) rsat = COORD_MIN;
        else                                 rsat = s[COORD_W-1:0];
    endfunction

    assign cubic    = job_reg.degree == DEG_CUBIC;
    assign u        = T_ONE - U_W'(t_reg);
    // cubic weight: (3p + 2^15) >> 16
    assign w_cub    = W_W'((PROD_W+2)'(prod_reg) + ((PROD_W+2)'(prod_reg) << 1)
                      + (PROD_W+2)'(32768) >> 16);
    // cubic end weight: (p + 2^15) >> 16
    assign w_rnd    = W_W'((prod_reg + PROD_W'(32768)) >> 16);
    assign r_sum    = {1'b0, r_reg} + {1'b0, job_reg.r};
    assign t_carry  = r_sum >= {1'b0, job_reg.n};

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        pop       = 1'b0;
        load_pt   = 1'b0;
        load_last = 1'b0;
        case (state_reg)
            BE_IDLE: pop       = !empty;
            BE_CALC: load_pt   = (step_reg == ST_OUT) && out_free;
            BE_LAST: load_last = out_free;
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BE_IDLE: if (pop) state_next = (rd_data.n == '0) ? BE_LAST : BE_CALC;
            BE_CALC: if (load_pt && idx_reg == SEG_W'(job_reg.n - SEG_W'(1)))
                         state_next = BE_LAST;
            BE_LAST: if (load_last) state_next = BE_IDLE;
            default: state_next = BE_IDLE;
        endcase
    end

    always_comb begin
        ma = '0;
        mb = '0;
        case (step_reg)
            ST_UU: begin ma = MA_W'(u);     mb = MB_W'(u);     end
            ST_TT: begin ma = MA_W'(t_reg); mb = MB_W'(t_reg); end
            ST_W1: begin
                ma = cubic ? za(uu_reg) : MA_W'(u);
                mb = MB_W'(t_reg);
            end
            ST_W2: begin ma = za(tt_reg);   mb = MB_W'(u);     end
            ST_W0: begin ma = za(uu_reg);   mb = MB_W'(u);     end
            ST_W3: begin ma = za(tt_reg);   mb = MB_W'(t_reg); end
            ST_X0: begin ma = za(w_reg[0]); mb = sc(job_reg.p0_x); end
            ST_Y0: begin ma = za(w_reg[0]); mb = sc(job_reg.p0_y); end
            ST_X1: begin ma = za(w_reg[1]); mb = sc(job_reg.p1_x); end
            ST_Y1: begin ma = za(w_reg[1]); mb = sc(job_reg.p1_y); end
            ST_X2: begin ma = za(w_reg[2]); mb = sc(job_reg.p2_x); end
            ST_Y2: begin ma = za(w_reg[2]); mb = sc(job_reg.p2_y); end
            ST_X3: begin ma = za(w_reg[3]); mb = sc(job_reg.p3_x); end
            ST_Y3: begin ma = za(w_reg[3]); mb = sc(job_reg.p3_y); end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BE_IDLE;
            step_reg      <= ST_UU;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (pop || load_pt) step_reg <= ST_UU;
            else if (state_reg == BE_CALC && step_reg != ST_OUT)
                step_reg <= step_reg + STEP_W'(1);
            if (load_pt || load_last) out_valid_reg <= 1'b1;
            else if (m_ready)         out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= ma * mb;
        if (pop) begin
            job_reg <= rd_data;
            idx_reg <= '0;
            t_reg   <= '0;
            r_reg   <= rd_data.n >> 1;
        end
        if (state_reg == BE_CALC) begin
            // each step consumes the product of the step before it
            case (step_reg)
                ST_UU: begin
                    accx_reg <= '0;
                    accy_reg <= '0;
                end
                ST_TT: begin
                    uu_reg <= prod_reg[W_W-1:0];
                    if (!cubic) w_reg[0] <= prod_reg[W_W-1:0];
                end
                ST_W1: begin
                    tt_reg <= prod_reg[W_W-1:0];
                    if (!cubic) w_reg[3] <= prod_reg[W_W-1:0];
                end
                ST_W2: w_reg[1] <= cubic ? w_cub : {prod_reg[W_W-2:0], 1'b0};
                ST_W0: w_reg[2] <= cubic ? w_cub : '0;
                ST_W3: if (cubic) w_reg[0] <= w_rnd;
                ST_X0: if (cubic) w_reg[3] <= w_rnd;
                ST_Y0, ST_Y1, ST_Y2, ST_Y3:
                    accx_reg <= accx_reg + prod_reg[ACC_W-1:0];
                ST_X1, ST_X2, ST_X3, ST_ACC:
                    accy_reg <= accy_reg + prod_reg[ACC_W-1:0];
                default: ;
            endcase
        end
        if (load_pt) begin
            out_reg.point_x     <= rsat(accx_reg);
            out_reg.point_y     <= rsat(accy_reg);
            out_reg.point_index <= idx_reg;
            out_reg.last        <= 1'b0;
            idx_reg <= idx_reg + SEG_W'(1);
            t_reg   <= T_W'(U_W'(t_reg) + job_reg.q + U_W'(t_carry));
            r_reg   <= t_carry ? SEG_W'(r_sum - {1'b0, job_reg.n}) : r_sum[SEG_W-1:0];
        end else if (load_last) begin
            out_reg.point_x     <= job_reg.p3_x;
            out_reg.point_y     <= job_reg.p3_y;
            out_reg.point_index <= job_reg.n;
            out_reg.last        <= 1'b1;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_rem_lt_n: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BE_CALC |-> r_reg < job_reg.n)
        else $error("t remainder out of range");

    a_idx_lt_n: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BE_CALC |-> idx_reg < job_reg.n)
        else $error("point index past segment count");

    a_first_t: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BE_CALC && idx_reg == '0 |-> t_reg == '0)
        else $error("first point not at t = 0");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |-> !load_pt && !load_last)
        else $error("output overwritten while stalled");

endmodule
